// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by subtractive_random_pick.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/srp_pkg.sv =====
// Types and constants of the subtractive random pick block.
// No dependencies; used by subtractive_random_pick, srp_pick_checker and the testbench.
package srp_pkg;

    // Table geometry: slots 1..55 in use, slot 0 writable but never drawn
    localparam int TABLE_LENGTH = 56;
    localparam int ADDR_W       = 6;
    localparam int WORD_W       = 31;
    localparam int COUNT_W      = 13;
    localparam int PICK_W       = 12;
    localparam int TOTAL_W      = 32;

    // Lag structure of the generator
    localparam logic [ADDR_W-1:0] LAG_NEAR    = 6'd34;
    localparam logic [ADDR_W-1:0] LAG_FORWARD = 6'd21;
    localparam logic [ADDR_W-1:0] LAG_BACK    = 6'd34;
    localparam logic [ADDR_W-1:0] LAST_SLOT   = 6'd55;
    localparam logic [ADDR_W-1:0] FIRST_SLOT  = 6'd1;

    // Counts above this are clamped
    localparam logic [COUNT_W-1:0] MAX_CANDIDATES = 13'd4096;

    // Remainder runs one dividend bit per cycle
    localparam logic [4:0] DIV_LAST_BIT = 5'(WORD_W - 1);

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_DRAW  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_POS   = 2'd2
    } t_mode;

endpackage

// ===== hw/rtl/srp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/subtractive_random_pick.sv =====
// Lagged subtractive random generator over a 55-word table with a pick by remainder.
// A draw goes from acceptance to the result register through two table reads
// through the single read port of the table RAM, one subtract, one write-back,
// 31 remainder steps (one dividend bit per cycle) and one output load.
// A draw with a zero count skips the remainder; a slot write or a position load
// goes straight to the output load. One request is in work at a time; the next
// is accepted while the previous result still waits in the output register.
// Depends on srp_pkg, srp_ram and assert_macros.svh.
`include "assert_macros.svh"

module subtractive_random_pick (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // slot_index[5:0], slot_value[36:6], pick_count[49:37]
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    // Result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,  // random_value[30:0], pick_index[42:31],
                                    // draw_total[74:43]
    output logic [0:0]  o_m_tuser   // pick_valid[0]
);

    localparam int AW = srp_pkg::ADDR_W;
    localparam int WW = srp_pkg::WORD_W;
    localparam int CW = srp_pkg::COUNT_W;
    localparam int PW = srp_pkg::PICK_W;
    localparam int TW = srp_pkg::TOTAL_W;
    localparam int TL = srp_pkg::TABLE_LENGTH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDA  = 7'b0000010,
        S_RDB  = 7'b0000100,
        S_SUB  = 7'b0001000,
        S_WB   = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Request field unpacking
    logic [AW-1:0]     s_idx;
    logic [WW-1:0]     s_val;
    logic [CW-1:0]     s_count;
    srp_pkg::t_mode    s_mode;
    logic              s_acc;

    assign s_idx   = i_s_tdata[5:0];
    assign s_val   = i_s_tdata[36:6];
    assign s_count = i_s_tdata[49:37];
    assign s_mode  = srp_pkg::t_mode'(i_s_tuser);

    t_state          r_state;
    logic [AW-1:0]   r_pos;
    logic [TW-1:0]   r_total;
    logic [TL-1:0]   r_valid;
    logic [AW-1:0]   r_next;
    logic [AW-1:0]   r_other;
    logic [CW-1:0]   r_divisor;
    logic            r_is_draw;
    logic            r_rd_vld;
    logic [WW-1:0]   r_a;
    logic [WW:0]     r_diff;
    logic [WW-1:0]   r_rv;
    logic [WW-1:0]   r_shift;
    logic [CW-1:0]   r_rem;
    logic [4:0]      r_bit_cnt;
    logic            r_m_valid;
    logic [WW-1:0]   r_m_rv;
    logic [PW-1:0]   r_m_pick;
    logic            r_m_pvld;
    logic [TW-1:0]   r_m_total;

    assign s_acc      = i_s_tvalid && (r_state == S_IDLE);
    assign o_s_tready = (r_state == S_IDLE);

    // Next position and its partner slot
    logic [AW:0]     pos_inc;
    logic [AW-1:0]   n_next;
    logic [AW-1:0]   n_other;
    logic [CW-1:0]   n_divisor;

    assign pos_inc   = {1'b0, r_pos} + 7'd1;
    assign n_next    = (pos_inc < 7'(TL)) ? pos_inc[AW-1:0] : srp_pkg::FIRST_SLOT;
    assign n_other   = (n_next > srp_pkg::LAG_NEAR) ? n_next - srp_pkg::LAG_BACK
                                                    : n_next + srp_pkg::LAG_FORWARD;
    assign n_divisor = (s_count > srp_pkg::MAX_CANDIDATES) ? srp_pkg::MAX_CANDIDATES
                                                           : s_count;

    // Table RAM ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [WW-1:0]   ram_rdata;
    logic [WW-1:0]   rd_word;
    logic [WW-1:0]   wb_value;
    logic            load_we;

    assign load_we   = s_acc && (s_mode == srp_pkg::MODE_WRITE) && (s_idx < 6'(TL));
    assign wb_value  = r_diff[WW] ? r_diff[WW-1:0] - 31'd1 : r_diff[WW-1:0];
    assign ram_we    = load_we || (r_state == S_WB);
    assign ram_waddr = (r_state == S_WB) ? r_next : s_idx;
    assign ram_wdata = (r_state == S_WB) ? wb_value : s_val;
    assign ram_raddr = (r_state == S_RDB) ? r_other : r_next;
    // Slots never written read as zero
    assign rd_word   = r_rd_vld ? ram_rdata : '0;

    srp_ram #(
        .WIDTH (WW),
        .DEPTH (TL)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One remainder step: shift in the next dividend bit, subtract if it fits
    logic [CW:0]     div_trial;
    logic [CW-1:0]   n_rem;

    assign div_trial = {r_rem, r_shift[WW-1]};
    assign n_rem     = (div_trial >= {1'b0, r_divisor}) ? CW'(div_trial - {1'b0, r_divisor})
                                                        : CW'(div_trial);

    // Valid bit tracking for the table and its read port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[ram_raddr];
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_total   <= '0;
            r_is_draw <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_is_draw <= (s_mode == srp_pkg::MODE_DRAW);
                        r_state   <= (s_mode == srp_pkg::MODE_DRAW) ? S_RDA : S_DONE;
                        case (s_mode)
                            srp_pkg::MODE_DRAW: begin
                                r_pos   <= n_next;
                                r_total <= r_total + 32'd1;
                            end
                            srp_pkg::MODE_POS: begin
                                r_pos <= s_idx;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RDA:  r_state <= S_RDB;
                S_RDB:  r_state <= S_SUB;
                S_SUB:  r_state <= S_WB;
                S_WB: begin
                    r_state <= (r_divisor != '0) ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (r_bit_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_next    <= n_next;
            r_other   <= n_other;
            r_divisor <= n_divisor;
        end
        if (r_state == S_RDB) begin
            r_a <= rd_word;
        end
        if (r_state == S_SUB) begin
            r_diff <= {1'b0, r_a} - {1'b0, rd_word};
        end
        if (r_state == S_WB) begin
            r_rv      <= wb_value;
            r_shift   <= wb_value;
            r_rem     <= '0;
            r_bit_cnt <= srp_pkg::DIV_LAST_BIT;
        end
        if (r_state == S_DIV) begin
            r_rem     <= n_rem;
            r_shift   <= {r_shift[WW-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - 5'd1;
        end
    end

    // Output register
    logic out_load;
    logic pick_ok;

    assign out_load = (r_state == S_DONE) && (!r_m_valid || i_m_tready);
    assign pick_ok  = r_is_draw && (r_divisor != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_rv    <= r_is_draw ? r_rv : '0;
            r_m_pick  <= pick_ok ? r_rem[PW-1:0] : '0;
            r_m_pvld  <= pick_ok;
            r_m_total <= r_total;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'd0, r_m_total, r_m_pick, r_m_rv};
    assign o_m_tuser  = r_m_pvld;

    // Checks
    `ASSERT_CLK(a_draw_counts, i_clk, i_rst_n,
        (s_acc && s_mode == srp_pkg::MODE_DRAW) |=> (r_total == $past(r_total) + 32'd1),
        "draw not counted once")
    `ASSERT_CLK(a_rem_below_div, i_clk, i_rst_n,
        (r_state == S_DONE && pick_ok) |-> (r_rem < r_divisor),
        "remainder not below count")
    `ASSERT_CLK(a_div_ends, i_clk, i_rst_n,
        (r_state == S_DIV && r_bit_cnt == '0) |=> (r_state == S_DONE),
        "remainder sequence overran")
    `ASSERT_NEVER(a_we_states, i_clk, i_rst_n,
        ram_we && !(r_state == S_WB || r_state == S_IDLE),
        "table written outside load or write-back")

endmodule

// ===== tb/sv/srp_pick_checker.sv =====
// Scoreboard for subtractive_random_pick: watches both stream channels,
// predicts each result from its own copy of the table, and counts mismatches.
// Depends on srp_pkg.
module srp_pick_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,  // slot_index[5:0], slot_value[36:6], pick_count[49:37]
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,  // random_value[30:0], pick_index[42:31],
                                    // draw_total[74:43]
    input  logic [0:0]  i_m_tuser,  // pick_valid[0]
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WRAP_ADD = 32'h7fff_ffff;

    typedef struct packed {
        logic [srp_pkg::WORD_W-1:0]  word;
        logic [srp_pkg::PICK_W-1:0]  pick;
        logic                        pick_valid;
        logic [srp_pkg::TOTAL_W-1:0] total;
    } t_pick_result;

    // Shadow state of the generator
    logic [srp_pkg::WORD_W-1:0]  gen_slots [srp_pkg::TABLE_LENGTH];
    logic [srp_pkg::ADDR_W-1:0]  gen_position;
    logic [srp_pkg::TOTAL_W-1:0] gen_draws;

    t_pick_result expected_picks [$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Apply one request to the shadow state and return the result it causes
    function automatic t_pick_result predict_pick(logic [1:0] mode,
                                                  logic [srp_pkg::ADDR_W-1:0] idx,
                                                  logic [srp_pkg::WORD_W-1:0] val,
                                                  logic [srp_pkg::COUNT_W-1:0] count);
        t_pick_result                res;
        logic [srp_pkg::ADDR_W-1:0]  next_slot;
        logic [srp_pkg::ADDR_W-1:0]  partner;
        logic [srp_pkg::COUNT_W-1:0] clamped;
        int unsigned                 lead;
        int unsigned                 lag;
        int unsigned                 word;
        int unsigned                 cand;
        res = '0;
        case (srp_pkg::t_mode'(mode))
            srp_pkg::MODE_DRAW: begin
                next_slot = (7'(gen_position) + 7'd1 < 7'(srp_pkg::TABLE_LENGTH))
                          ? gen_position + 6'd1 : srp_pkg::FIRST_SLOT;
                partner = (next_slot > srp_pkg::LAG_NEAR) ? next_slot - srp_pkg::LAG_BACK
                                                          : next_slot + srp_pkg::LAG_FORWARD;
                lead = 32'(gen_slots[next_slot]);
                lag  = 32'(gen_slots[partner]);
                // negative difference wraps by adding 2^31-1
                word = (lead >= lag) ? lead - lag : lead + WRAP_ADD - lag;
                gen_slots[next_slot] = word[srp_pkg::WORD_W-1:0];
                gen_position = next_slot;
                gen_draws = gen_draws + 32'd1;
                res.word = word[srp_pkg::WORD_W-1:0];
                clamped = (count > srp_pkg::MAX_CANDIDATES) ? srp_pkg::MAX_CANDIDATES : count;
                cand = 32'(clamped);
                if (cand != 0) begin
                    res.pick = srp_pkg::PICK_W'(word % cand);
                    res.pick_valid = 1'b1;
                end
            end
            srp_pkg::MODE_WRITE: begin
                if (idx < srp_pkg::TABLE_LENGTH)
                    gen_slots[idx] = val;
            end
            srp_pkg::MODE_POS: begin
                gen_position = idx;
            end
            default: ;  // unused mode leaves everything alone
        endcase
        res.total = gen_draws;
        return res;
    endfunction

    // Track both channels; results are compared before new requests are queued
    always @(posedge i_clk) begin
        t_pick_result got;
        t_pick_result want;
        if (!i_rst_n) begin
            foreach (gen_slots[k])
                gen_slots[k] = '0;
            gen_position = '0;
            gen_draws = '0;
            expected_picks.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.word       = i_m_tdata[30:0];
                got.pick       = i_m_tdata[42:31];
                got.total      = i_m_tdata[74:43];
                got.pick_valid = i_m_tuser[0];
                if (expected_picks.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending", got));
                end else begin
                    want = expected_picks.pop_front();
                    if (got.word !== want.word)
                        report_mismatch($sformatf("random_value %h, expected %h",
                                                  got.word, want.word));
                    if (got.pick !== want.pick)
                        report_mismatch($sformatf("pick_index %0d, expected %0d",
                                                  got.pick, want.pick));
                    if (got.pick_valid !== want.pick_valid)
                        report_mismatch($sformatf("pick_valid %b, expected %b",
                                                  got.pick_valid, want.pick_valid));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("draw_total %0d, expected %0d",
                                                  got.total, want.total));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_picks.push_back(predict_pick(i_s_tuser, i_s_tdata[5:0],
                                                      i_s_tdata[36:6], i_s_tdata[49:37]));
        end
        o_pending <= expected_picks.size();
    end

endmodule

// ===== tb/sv/tb_subtractive_random_pick.sv =====
// Top of the subtractive_random_pick testbench: clock, reset, request and
// result stimulus with random idling, and the verdict.
// Depends on srp_pkg, subtractive_random_pick and srp_pick_checker.
module tb_subtractive_random_pick;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int          HOLD_AT      = 400;
    localparam int          PAUSE_AT     = 900;
    localparam int          TAIL_CYCLES  = 60;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam logic [srp_pkg::WORD_W-1:0] WORD_MAX = 31'h7fff_fffe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;  // slot_index[5:0], slot_value[36:6], pick_count[49:37]
    logic [1:0]  s_tuser = '0;  // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;       // random_value[30:0], pick_index[42:31], draw_total[74:43]
    logic [0:0]  m_tuser;       // pick_valid[0]

    int fail_count;
    int pending;
    int requests_sent = 0;
    int hold_asks = 0;
    int holds_done = 0;
    int unsigned cycles = 0;

    always #10 i_clk = ~i_clk;

    subtractive_random_pick dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    srp_pick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned gap_cycles();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Candidate counts: mostly small, some zero, some at or past the clamp
    function automatic logic [srp_pkg::COUNT_W-1:0] draw_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return srp_pkg::COUNT_W'($urandom_range(1, 64));
        if (roll < 75) return srp_pkg::COUNT_W'($urandom_range(65, 4096));
        if (roll < 85) return '0;
        return srp_pkg::COUNT_W'($urandom_range(4097, 8191));
    endfunction

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, calm phases, and the long hold-off on request
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned phase_left = 0;
    int unsigned stall_pct = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != holds_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left <= gap_cycles();
        end
        if (phase_left == 0) begin
            phase_left <= $urandom_range(100, 400);
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                default: stall_pct <= 35;
            endcase
        end else begin
            phase_left <= phase_left - 1;
        end
    end

    // Request side
    bit calm_sender = 1'b0;

    task automatic send_request(logic [1:0] mode, logic [srp_pkg::ADDR_W-1:0] idx,
                                logic [srp_pkg::WORD_W-1:0] val,
                                logic [srp_pkg::COUNT_W-1:0] count);
        if (requests_sent % 100 == 0)
            calm_sender = ($urandom_range(0, 99) < 30);
        if (!calm_sender && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles()) @(posedge i_clk);
        end
        s_tdata  <= {6'b0, count, val, idx};
        s_tuser  <= mode;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic seed_table();
        for (int k = int'(srp_pkg::FIRST_SLOT); k <= int'(srp_pkg::LAST_SLOT); k++)
            send_request(srp_pkg::MODE_WRITE, srp_pkg::ADDR_W'(k),
                         srp_pkg::WORD_W'($urandom_range(0, WORD_MAX)), draw_count());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int unsigned roll;
        bit          paused;
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset table, slot zero, out-of-range writes, wrap points, clamps
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd5);
        send_request(srp_pkg::MODE_WRITE, 6'd0, WORD_MAX, 13'd0);
        send_request(srp_pkg::MODE_WRITE, 6'd1, WORD_MAX, 13'd0);
        send_request(srp_pkg::MODE_WRITE, 6'd22, '0, 13'd8191);
        send_request(srp_pkg::MODE_WRITE, 6'd56, 31'h0000_007b, 13'd0);
        send_request(srp_pkg::MODE_WRITE, 6'd63, 31'h2aaa_aaaa, 13'd0);
        send_request(srp_pkg::MODE_WRITE, 6'd55, 31'h5555_5555, 13'd0);
        send_request(srp_pkg::MODE_WRITE, 6'd21, WORD_MAX, 13'd0);
        send_request(srp_pkg::MODE_POS, 6'd0, '0, 13'd0);
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd1);
        send_request(srp_pkg::MODE_POS, 6'd54, '0, 13'd0);
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd4096);
        send_request(srp_pkg::MODE_POS, 6'd55, '0, 13'd0);
        send_request(srp_pkg::MODE_DRAW, 6'd63, WORD_MAX, 13'd8191);
        send_request(srp_pkg::MODE_POS, 6'd63, '0, 13'd0);
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd4097);
        send_request(srp_pkg::MODE_POS, 6'd34, '0, 13'd0);
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd0);
        send_request(srp_pkg::MODE_POS, 6'd33, '0, 13'd0);
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd3);
        send_request(MODE_UNUSED, 6'd63, WORD_MAX, 13'd8191);
        send_request(srp_pkg::MODE_DRAW, 6'd0, '0, 13'd2);
        send_request(MODE_UNUSED, 6'd0, '0, 13'd0);

        // Random: a seeded table, then mostly draws with loads and noise mixed in
        seed_table();
        while (requests_sent < RANDOM_ITEMS) begin
            if (requests_sent >= HOLD_AT && hold_asks == 0)
                hold_asks <= 1;
            if (requests_sent >= PAUSE_AT && !paused) begin
                paused = 1'b1;
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 82)
                send_request(srp_pkg::MODE_DRAW, 6'($urandom), 31'($urandom), draw_count());
            else if (roll < 89)
                send_request(srp_pkg::MODE_WRITE, 6'($urandom_range(0, 63)),
                             srp_pkg::WORD_W'($urandom_range(0, WORD_MAX)), 13'($urandom));
            else if (roll < 94)
                send_request(srp_pkg::MODE_POS, 6'($urandom_range(0, 63)), 31'($urandom),
                             13'($urandom));
            else if (roll < 99)
                send_request(MODE_UNUSED, 6'($urandom), 31'($urandom), 13'($urandom));
            else
                seed_table();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
